FILE: hdl/rpn_pkg.sv
// Package with the command, error, state and word types of the RPN stack calculator.
package rpn_pkg;

  typedef enum logic [3:0] {
    CMD_PUSH  = 4'd0,
    CMD_ADD   = 4'd1,
    CMD_SUB   = 4'd2,
    CMD_MUL   = 4'd3,
    CMD_DIV   = 4'd4,
    CMD_MOD   = 4'd5,
    CMD_PEEK  = 4'd6,
    CMD_DUP   = 4'd7,
    CMD_SWAP  = 4'd8,
    CMD_CLEAR = 4'd9,
    CMD_LINE  = 4'd10
  } cmd_e;

  typedef enum logic [2:0] {
    ERR_NONE    = 3'd0,
    ERR_FULL    = 3'd1,
    ERR_EMPTY   = 3'd2,
    ERR_ZDIV    = 3'd3,
    ERR_SWAP    = 3'd4,
    ERR_UNKNOWN = 3'd5
  } err_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RDB,
    ST_RDA,
    ST_MUL,
    ST_DIV,
    ST_FIX,
    ST_WR,
    ST_SWB
  } state_e;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [3:0]         command;
    logic signed [31:0] operand_value;
  } cmd_word_t;

  typedef struct packed {
    logic               shown;
    logic signed [31:0] shown_value;
    logic [2:0]         error_code;
  } result_word_t;

endpackage

FILE: hdl/rpn_stack_calculator_top.sv
// Top level of the RPN stack calculator: command sequencer around the stack memory.
// One command word is taken when start is high and busy is low; its result word
// appears on result for exactly one cycle with strobe high, and must be taken then.
// Push, clear, unknown codes, skipped line ends and commands that fail at once finish
// in idle; peek, line end and dup read the top entry first, and swap, add, sub and mul
// read both top entries, because each entry is read from the memory as registered read
// data and written back through its single write port. Div and mod wait for the divider
// that forms one quotient bit per cycle over 48 steps.
module rpn_stack_calculator_top #(
  parameter int STACK_DEPTH = 128
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  rpn_pkg::cmd_word_t   cmd,
  output logic                 strobe,
  output rpn_pkg::result_word_t result
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  rpn_pkg::state_e    state, state_next;
  rpn_pkg::cmd_word_t cmd_r, cmd_r_next;
  logic [CW-1:0]      cnt, cnt_next;
  logic               skip, skip_next;
  logic signed [31:0] b_r, b_r_next;
  logic signed [31:0] a_r, a_r_next;
  logic signed [31:0] res, res_next;
  logic signed [63:0] prod, prod_next;
  logic [AW-1:0]      wr_addr, wr_addr_next;
  logic               shown, shown_next;
  logic signed [31:0] sval, sval_next;
  logic [2:0]         err, err_next;
  logic               strobe_next;

  logic [CW-1:0]      cm1, cm2;
  logic               we;
  logic [AW-1:0]      waddr, raddr;
  logic [31:0]        wdata, rd_data;
  logic signed [31:0] a_val;
  logic [32:0]        sum;
  logic [31:0]        a_mag, b_mag;
  logic               div_start, div_done;
  logic [47:0]        div_dividend, quo;
  logic [31:0]        rem;
  logic               neg;

  assign cm1   = cnt - CW'(1);
  assign cm2   = cnt - CW'(2);
  assign a_val = (cnt >= CW'(2)) ? $signed(rd_data) : 32'sd0;
  assign a_mag = a_val[31] ? 32'(-a_val) : 32'(a_val);
  assign b_mag = b_r[31] ? 32'(-b_r) : 32'(b_r);
  assign neg   = a_r[31] ^ b_r[31];

  assign busy   = (state != rpn_pkg::ST_IDLE);
  assign result = '{shown: shown, shown_value: sval, error_code: err};

  rpn_stack_ram #(.DEPTH(STACK_DEPTH), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd_data)
  );

  rpn_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (b_mag),
    .done      (div_done),
    .quotient  (quo),
    .remainder (rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= rpn_pkg::ST_IDLE;
      cnt    <= '0;
      skip   <= 1'b0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      cnt    <= cnt_next;
      skip   <= skip_next;
      strobe <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_r_next;
    b_r     <= b_r_next;
    a_r     <= a_r_next;
    res     <= res_next;
    prod    <= prod_next;
    wr_addr <= wr_addr_next;
    shown   <= shown_next;
    sval    <= sval_next;
    err     <= err_next;
  end

  always_comb begin
    state_next   = state;
    cmd_r_next   = cmd_r;
    cnt_next     = cnt;
    skip_next    = skip;
    b_r_next     = b_r;
    a_r_next     = a_r;
    res_next     = res;
    prod_next    = prod;
    wr_addr_next = wr_addr;
    shown_next   = shown;
    sval_next    = sval;
    err_next     = err;
    strobe_next  = 1'b0;
    we           = 1'b0;
    waddr        = wr_addr;
    wdata        = res;
    raddr        = cm1[AW-1:0];
    div_start    = 1'b0;
    div_dividend = '0;
    sum          = '0;

    case (state)
      rpn_pkg::ST_IDLE: begin
        if (start) begin
          cmd_r_next = cmd;
          err_next   = rpn_pkg::ERR_NONE;
          shown_next = 1'b0;
          sval_next  = '0;
          case (rpn_pkg::cmd_e'(cmd.command))
            rpn_pkg::CMD_PUSH: begin
              strobe_next = 1'b1;
              if (cnt < CW'(STACK_DEPTH)) begin
                we       = 1'b1;
                waddr    = cnt[AW-1:0];
                wdata    = cmd.operand_value;
                cnt_next = cnt + CW'(1);
              end else begin
                err_next = rpn_pkg::ERR_FULL;
              end
            end
            rpn_pkg::CMD_ADD, rpn_pkg::CMD_SUB, rpn_pkg::CMD_MUL,
            rpn_pkg::CMD_DIV, rpn_pkg::CMD_MOD: begin
              state_next = rpn_pkg::ST_RDB;
            end
            rpn_pkg::CMD_PEEK: begin
              skip_next = 1'b1;
              if (cnt == '0) begin
                err_next    = rpn_pkg::ERR_EMPTY;
                strobe_next = 1'b1;
              end else begin
                state_next = rpn_pkg::ST_RDB;
              end
            end
            rpn_pkg::CMD_DUP: begin
              skip_next = 1'b1;
              if (cnt == '0) begin
                err_next    = rpn_pkg::ERR_EMPTY;
                strobe_next = 1'b1;
              end else if (cnt == CW'(STACK_DEPTH)) begin
                err_next    = rpn_pkg::ERR_FULL;
                strobe_next = 1'b1;
              end else begin
                state_next = rpn_pkg::ST_RDB;
              end
            end
            rpn_pkg::CMD_SWAP: begin
              skip_next = 1'b1;
              if (cnt < CW'(2)) begin
                err_next    = rpn_pkg::ERR_SWAP;
                strobe_next = 1'b1;
              end else begin
                state_next = rpn_pkg::ST_RDB;
              end
            end
            rpn_pkg::CMD_CLEAR: begin
              cnt_next    = '0;
              skip_next   = 1'b1;
              strobe_next = 1'b1;
            end
            rpn_pkg::CMD_LINE: begin
              skip_next = 1'b0;
              if (skip) begin
                strobe_next = 1'b1;
              end else begin
                shown_next = 1'b1;
                if (cnt == '0) begin
                  err_next    = rpn_pkg::ERR_EMPTY;
                  strobe_next = 1'b1;
                end else begin
                  state_next = rpn_pkg::ST_RDB;
                end
              end
            end
            default: begin
              err_next    = rpn_pkg::ERR_UNKNOWN;
              strobe_next = 1'b1;
            end
          endcase
        end
      end

      rpn_pkg::ST_RDB: begin
        // The top entry arrives now; the entry below it is requested.
        raddr    = cm2[AW-1:0];
        b_r_next = (cnt == '0) ? 32'sd0 : $signed(rd_data);
        case (rpn_pkg::cmd_e'(cmd_r.command))
          rpn_pkg::CMD_PEEK: begin
            shown_next  = 1'b1;
            sval_next   = rd_data;
            strobe_next = 1'b1;
            state_next  = rpn_pkg::ST_IDLE;
          end
          rpn_pkg::CMD_LINE: begin
            sval_next   = rd_data;
            cnt_next    = cm1;
            strobe_next = 1'b1;
            state_next  = rpn_pkg::ST_IDLE;
          end
          rpn_pkg::CMD_DUP: begin
            we          = 1'b1;
            waddr       = cnt[AW-1:0];
            wdata       = rd_data;
            cnt_next    = cnt + CW'(1);
            strobe_next = 1'b1;
            state_next  = rpn_pkg::ST_IDLE;
          end
          rpn_pkg::CMD_DIV, rpn_pkg::CMD_MOD: begin
            if (cnt == '0) begin
              err_next = rpn_pkg::ERR_EMPTY;
            end
            if (cnt == '0 || rd_data == '0) begin
              // Zero divisor: it is dropped and the dividend stays.
              if (cnt != '0) begin
                err_next = rpn_pkg::ERR_ZDIV;
                cnt_next = cm1;
              end
              strobe_next = 1'b1;
              state_next  = rpn_pkg::ST_IDLE;
            end else begin
              state_next = rpn_pkg::ST_RDA;
            end
          end
          default: begin
            if (cnt == '0) begin
              err_next = rpn_pkg::ERR_EMPTY;
            end
            state_next = rpn_pkg::ST_RDA;
          end
        endcase
      end

      rpn_pkg::ST_RDA: begin
        a_r_next     = a_val;
        wr_addr_next = (cnt >= CW'(2)) ? cm2[AW-1:0] : '0;
        if (cnt < CW'(2) && err == rpn_pkg::ERR_NONE) begin
          err_next = rpn_pkg::ERR_EMPTY;
        end
        case (rpn_pkg::cmd_e'(cmd_r.command))
          rpn_pkg::CMD_SWAP: begin
            we         = 1'b1;
            waddr      = cm1[AW-1:0];
            wdata      = rd_data;
            state_next = rpn_pkg::ST_SWB;
          end
          rpn_pkg::CMD_ADD, rpn_pkg::CMD_SUB: begin
            if (rpn_pkg::cmd_e'(cmd_r.command) == rpn_pkg::CMD_ADD) begin
              sum = {a_val[31], a_val} + {b_r[31], b_r};
            end else begin
              sum = {a_val[31], a_val} - {b_r[31], b_r};
            end
            if (sum[32] != sum[31]) begin
              res_next = sum[32] ? rpn_pkg::Q_MIN : rpn_pkg::Q_MAX;
            end else begin
              res_next = sum[31:0];
            end
            state_next = rpn_pkg::ST_WR;
          end
          rpn_pkg::CMD_MUL: begin
            prod_next  = a_val * b_r;
            state_next = rpn_pkg::ST_MUL;
          end
          default: begin
            div_start = 1'b1;
            if (rpn_pkg::cmd_e'(cmd_r.command) == rpn_pkg::CMD_DIV) begin
              div_dividend = {a_mag, 16'h0000};
            end else begin
              div_dividend = {16'h0000, a_mag};
            end
            state_next = rpn_pkg::ST_DIV;
          end
        endcase
      end

      rpn_pkg::ST_MUL: begin
        // An arithmetic shift of the product rounds toward minus infinity.
        if (prod[63:47] != {17{prod[63]}}) begin
          res_next = prod[63] ? rpn_pkg::Q_MIN : rpn_pkg::Q_MAX;
        end else begin
          res_next = prod[47:16];
        end
        state_next = rpn_pkg::ST_WR;
      end

      rpn_pkg::ST_DIV: begin
        if (div_done) begin
          state_next = rpn_pkg::ST_FIX;
        end
      end

      rpn_pkg::ST_FIX: begin
        if (rpn_pkg::cmd_e'(cmd_r.command) == rpn_pkg::CMD_DIV) begin
          if (!neg) begin
            res_next = (quo > 48'h0000_7FFF_FFFF) ? rpn_pkg::Q_MAX : quo[31:0];
          end else begin
            res_next = (quo > 48'h0000_8000_0000) ? rpn_pkg::Q_MIN : -quo[31:0];
          end
        end else begin
          res_next = a_r[31] ? -rem : rem;
        end
        state_next = rpn_pkg::ST_WR;
      end

      rpn_pkg::ST_WR: begin
        we          = 1'b1;
        cnt_next    = CW'(wr_addr) + CW'(1);
        strobe_next = 1'b1;
        state_next  = rpn_pkg::ST_IDLE;
      end

      rpn_pkg::ST_SWB: begin
        we          = 1'b1;
        waddr       = cm2[AW-1:0];
        wdata       = b_r;
        strobe_next = 1'b1;
        state_next  = rpn_pkg::ST_IDLE;
      end

      default: begin
        state_next = rpn_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: hdl/rpn_stack_ram.sv
// Stack memory: one write port and one read port with registered read data.
module rpn_stack_ram #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/rpn_divider.sv
// Unsigned restoring divider, one quotient bit per cycle, 48-bit dividend by 32-bit divisor.
module rpn_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [47:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [47:0] quotient,
  output logic [31:0] remainder
);

  localparam int Steps = 48;

  logic [5:0]  step;
  logic        running;
  logic [32:0] rem;
  logic [31:0] dvs;
  logic [32:0] rem_sh;
  logic [33:0] diff;

  assign rem_sh    = {rem[31:0], quotient[47]};
  assign diff      = {1'b0, rem_sh} - {2'b00, dvs};
  assign remainder = rem[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        step    <= '0;
      end else if (running) begin
        step <= step + 6'd1;
        if (step == 6'(Steps - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (running) begin
      if (!diff[33]) begin
        rem      <= diff[32:0];
        quotient <= {quotient[46:0], 1'b1};
      end else begin
        rem      <= rem_sh;
        quotient <= {quotient[46:0], 1'b0};
      end
    end
  end

endmodule

FILE: dv/rpn_stack_calculator_checker.sv
// Checker for the RPN stack calculator: predicts each result word and compares it.
module rpn_stack_calculator_checker #(
  parameter int STACK_DEPTH = 128
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  busy,
  input  rpn_pkg::cmd_word_t    cmd,
  input  logic                  strobe,
  input  rpn_pkg::result_word_t result,
  output int                    fail_count,
  output int                    pending_results
);

  logic signed [31:0] calc_stack [STACK_DEPTH];
  int unsigned calc_depth;
  bit line_show_skipped;
  rpn_pkg::err_e first_err;
  rpn_pkg::result_word_t expected_results [$];

  function automatic void flag_err(rpn_pkg::err_e code);
    if (first_err == rpn_pkg::ERR_NONE) first_err = code;
  endfunction

  function automatic logic signed [31:0] clamp32(logic signed [65:0] v);
    if (v > 66'sd2147483647) return rpn_pkg::Q_MAX;
    if (v < -66'sd2147483648) return rpn_pkg::Q_MIN;
    return v[31:0];
  endfunction

  function automatic void push_word(logic signed [31:0] v);
    if (calc_depth < STACK_DEPTH) begin
      calc_stack[calc_depth] = v;
      calc_depth++;
    end else flag_err(rpn_pkg::ERR_FULL);
  endfunction

  function automatic logic signed [31:0] pop_word();
    if (calc_depth > 0) begin
      calc_depth--;
      return calc_stack[calc_depth];
    end
    flag_err(rpn_pkg::ERR_EMPTY);
    return 32'sd0;
  endfunction

  function automatic rpn_pkg::result_word_t compute_result(rpn_pkg::cmd_word_t w);
    logic signed [31:0] a, b, t;
    logic signed [65:0] wide;
    rpn_pkg::result_word_t r;
    r = '0;
    first_err = rpn_pkg::ERR_NONE;
    case (w.command)
      rpn_pkg::CMD_PUSH: push_word(w.operand_value);
      rpn_pkg::CMD_ADD, rpn_pkg::CMD_SUB, rpn_pkg::CMD_MUL: begin
        b = pop_word();
        a = pop_word();
        if (w.command == rpn_pkg::CMD_ADD) wide = 66'(a) + 66'(b);
        else if (w.command == rpn_pkg::CMD_SUB) wide = 66'(a) - 66'(b);
        else wide = (66'(a) * 66'(b)) >>> 16;  // arithmetic shift floors
        push_word(clamp32(wide));
      end
      rpn_pkg::CMD_DIV, rpn_pkg::CMD_MOD: begin
        b = pop_word();
        if (b == 0) flag_err(rpn_pkg::ERR_ZDIV);
        else begin
          a = pop_word();
          if (w.command == rpn_pkg::CMD_DIV) begin
            push_word(clamp32((66'(a) <<< 16) / 66'(b)));
          end else begin
            wide = 66'(a) % 66'(b);
            push_word(wide[31:0]);
          end
        end
      end
      rpn_pkg::CMD_PEEK: begin
        if (calc_depth > 0) begin
          r.shown = 1'b1;
          r.shown_value = calc_stack[calc_depth - 1];
        end else flag_err(rpn_pkg::ERR_EMPTY);
        line_show_skipped = 1'b1;
      end
      rpn_pkg::CMD_DUP: begin
        if (calc_depth < 1) flag_err(rpn_pkg::ERR_EMPTY);
        else begin
          a = pop_word();
          push_word(a);
          push_word(a);
        end
        line_show_skipped = 1'b1;
      end
      rpn_pkg::CMD_SWAP: begin
        if (calc_depth < 2) flag_err(rpn_pkg::ERR_SWAP);
        else begin
          t = calc_stack[calc_depth - 1];
          calc_stack[calc_depth - 1] = calc_stack[calc_depth - 2];
          calc_stack[calc_depth - 2] = t;
        end
        line_show_skipped = 1'b1;
      end
      rpn_pkg::CMD_CLEAR: begin
        calc_depth = 0;
        line_show_skipped = 1'b1;
      end
      rpn_pkg::CMD_LINE: begin
        if (!line_show_skipped) begin
          r.shown = 1'b1;
          r.shown_value = pop_word();
        end
        line_show_skipped = 1'b0;
      end
      default: flag_err(rpn_pkg::ERR_UNKNOWN);
    endcase
    r.error_code = first_err;
    return r;
  endfunction

  always @(posedge clk) begin
    rpn_pkg::result_word_t exp_word;
    int errs;
    errs = 0;
    if (rst) begin
      calc_depth = 0;
      line_show_skipped = 1'b0;
      expected_results.delete();
      fail_count <= 0;
    end else begin
      // A result may come out at the same edge a new word goes in, so check first.
      if (strobe) begin
        if (expected_results.size() == 0) begin
          $error("result word with none expected: %h", result);
          errs++;
        end else begin
          exp_word = expected_results.pop_front();
          if (result.shown !== exp_word.shown) begin
            $error("shown: expected %0d, got %0d", exp_word.shown, result.shown);
            errs++;
          end
          if (result.shown_value !== exp_word.shown_value) begin
            $error("shown_value: expected %0d, got %0d", exp_word.shown_value,
                   result.shown_value);
            errs++;
          end
          if (result.error_code !== exp_word.error_code) begin
            $error("error_code: expected %0d, got %0d", exp_word.error_code,
                   result.error_code);
            errs++;
          end
        end
      end
      if (start && !busy) expected_results.push_back(compute_result(cmd));
      fail_count <= fail_count + errs;
    end
    pending_results <= expected_results.size();
  end
endmodule

FILE: dv/rpn_stack_calculator_top_tb.sv
// Testbench top for the RPN stack calculator: clock, reset, command stimulus and verdict.
module rpn_stack_calculator_top_tb;

  localparam int DEPTH = 128;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  rpn_pkg::cmd_word_t cmd = '0;
  logic strobe;
  rpn_pkg::result_word_t result;
  int fail_count;
  int pending_results;
  int model_depth;
  bit quiet_end;

  always #10 clk = ~clk;

  rpn_stack_calculator_top #(.STACK_DEPTH(DEPTH)) uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .strobe(strobe), .result(result)
  );

  rpn_stack_calculator_checker #(.STACK_DEPTH(DEPTH)) checker_i (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .strobe(strobe), .result(result), .fail_count(fail_count),
    .pending_results(pending_results)
  );

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return 32'sd0;
      3: return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
      4: return 32'sh0001_0000 * ($signed($urandom_range(0, 20)) - 10);
      default: return $urandom();
    endcase
  endfunction

  // Sends one word; the depth tracked here only steers the random mix.
  task automatic send_word(logic [3:0] code, logic signed [31:0] value);
    int gap;
    if (!quiet_end && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= '{command: code, operand_value: value};
    @(posedge clk);
    while (busy) @(posedge clk);
    case (code)
      rpn_pkg::CMD_PUSH: if (model_depth < DEPTH) model_depth++;
      rpn_pkg::CMD_ADD, rpn_pkg::CMD_SUB, rpn_pkg::CMD_MUL, rpn_pkg::CMD_DIV,
      rpn_pkg::CMD_MOD, rpn_pkg::CMD_LINE:
        if (model_depth > 0) model_depth--;
      rpn_pkg::CMD_DUP: if (model_depth > 0 && model_depth < DEPTH) model_depth++;
      rpn_pkg::CMD_CLEAR: model_depth = 0;
      default: ;
    endcase
  endtask

  task automatic random_word();
    logic [3:0] code;
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) code = 4'($urandom_range(11, 15));
    else if (r < 35 || model_depth < 2) code = rpn_pkg::CMD_PUSH;
    else code = 4'($urandom_range(1, 10));
    if (code == rpn_pkg::CMD_CLEAR && $urandom_range(0, 3) != 0) code = rpn_pkg::CMD_PUSH;
    if ((code == rpn_pkg::CMD_DIV || code == rpn_pkg::CMD_MOD) &&
        $urandom_range(0, 2) == 0) begin
      send_word(rpn_pkg::CMD_PUSH, pick_value());
      code = rpn_pkg::CMD_PUSH;
    end
    send_word(code, code == rpn_pkg::CMD_PUSH ? pick_value() : $urandom());
  endtask

  initial begin
    int k;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Empty stack cases, then the field extremes.
    send_word(rpn_pkg::CMD_LINE, 0);
    send_word(rpn_pkg::CMD_ADD, 0);
    send_word(rpn_pkg::CMD_PEEK, 0);
    send_word(rpn_pkg::CMD_LINE, 0);
    send_word(rpn_pkg::CMD_DUP, 0);
    send_word(rpn_pkg::CMD_SWAP, 0);
    send_word(4'd15, 32'hFFFF_FFFF);
    send_word(4'd11, 0);
    send_word(rpn_pkg::CMD_PUSH, 32'sh7FFF_FFFF);
    send_word(rpn_pkg::CMD_PUSH, 32'sh7FFF_FFFF);
    send_word(rpn_pkg::CMD_MUL, 0);
    send_word(rpn_pkg::CMD_PUSH, 32'sh8000_0000);
    send_word(rpn_pkg::CMD_SWAP, 0);
    send_word(rpn_pkg::CMD_SUB, 0);
    send_word(rpn_pkg::CMD_PUSH, 32'sh0000_0001);
    send_word(rpn_pkg::CMD_DIV, 0);
    send_word(rpn_pkg::CMD_PUSH, 32'sd0);
    send_word(rpn_pkg::CMD_MOD, 0);
    send_word(rpn_pkg::CMD_PUSH, -32'sh0003_8000);
    send_word(rpn_pkg::CMD_PUSH, 32'sh0002_0000);
    send_word(rpn_pkg::CMD_MOD, 0);
    send_word(rpn_pkg::CMD_LINE, 0);
    send_word(rpn_pkg::CMD_CLEAR, 0);
    send_word(rpn_pkg::CMD_LINE, 0);
    // Fill past full, then dup on a full stack.
    for (k = 0; k <= DEPTH; k++) send_word(rpn_pkg::CMD_PUSH, pick_value());
    send_word(rpn_pkg::CMD_DUP, 0);
    send_word(rpn_pkg::CMD_ADD, 0);
    send_word(rpn_pkg::CMD_CLEAR, 0);
    for (k = 0; k < 1000; k++) begin
      if (k == 900) quiet_end = 1'b1;
      random_word();
    end
    start <= 1'b0;
    while (pending_results != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #20000000;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
